/* src/mwf_pkg.sv */
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types and constants for the morphological window filter.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WINDOW = 15;

  localparam int COL_W   = $clog2(MAX_WIDTH);        // 10
  localparam int DIM_W   = COL_W + 1;                // 11
  localparam int SLOT_W  = $clog2(MAX_WINDOW);       // 4
  localparam int RAD_W   = 3;
  localparam int LAT_W   = 15;
  localparam int CNT_W   = 21;
  localparam int CFG_DW  = 11;
  localparam int CFG_AW  = 8;

  localparam logic [7:0] WHITE = 8'd255;

  localparam logic [CFG_AW-1:0] REG_MODE   = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_LENGTH = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_WIDTH  = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_HEIGHT = CFG_AW'(3);

  typedef enum logic [1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_GMIN   = 2'd2,
    MODE_GMAX   = 2'd3
  } mode_t;

  // per-item control carried down the pipe
  typedef struct packed {
    logic             emit;
    logic             inner;
    logic             fin;
    logic [COL_W-1:0] cr;
    logic [COL_W-1:0] cc;
  } ctl_t;

endpackage

/* src/morphological_window_filter.sv */
// ----------------------------------------------------------------------------
// morphological_window_filter
// Binary/grayscale erosion and dilation over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel (or pad) per clock and returns at most one filtered centre
// per transfer, one item per cycle sustained while out_stall is low. Three
// register stages sit between input and output: the line buffer read (15 row
// banks, one read each per cycle), the column reduction into the horizontal
// history, and the result register. A centre enters the stages R*W+R
// transfers after its pixel. Pads flush the tail; the position returns to
// the image start after the centre flagged last, and on mapped config writes.
module morphological_window_filter import mwf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_value,
  output logic [COL_W-1:0]  out_row,
  output logic [COL_W-1:0]  out_col,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  mode_t             mode_r;
  logic [3:0]        len_r;
  logic [DIM_W-1:0]  width_r, height_r;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [RAD_W-1:0]  rad;
  logic [DIM_W-1:0]  rad11;
  logic [LAT_W-1:0]  lat;

  logic [DIM_W-1:0]  in_row_r;
  logic [COL_W-1:0]  in_col_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  k_r;
  logic [COL_W-1:0]  cr_r, cc_r;

  logic              pipe_en, in_acc, cfg_acc;
  logic [7:0]        px;
  logic              row_in_img, col_wrap;
  ctl_t              ctl0;

  logic [7:0]        rd_r [MAX_WINDOW];
  logic              v1_r, v2_r;
  ctl_t              ctl1_r, ctl2_r;
  logic [7:0]        px1_r;
  logic [SLOT_W-1:0] slot1_r;

  logic [MAX_WINDOW-1:0] hall_r, hany_r;
  logic [7:0]        hmin_r [3];
  logic [7:0]        hmax_r [3];

  logic              col_all, col_any;
  logic [7:0]        cmin, cmax;
  logic [SLOT_W-1:0] i1, i2;

  logic              out_valid_r, out_last_r;
  logic [7:0]        out_value_r, value_nxt;
  logic [COL_W-1:0]  out_row_r, out_col_r;

  // effective configuration
  always_comb begin
    w_eff = width_r;
    if (width_r == '0) w_eff = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = height_r;
    if (height_r == '0) h_eff = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    rad   = mode_r[1] ? RAD_W'(1) : len_r[3:1];
    rad11 = DIM_W'(rad);
    lat   = LAT_W'(LAT_W'(rad) * LAT_W'(w_eff)) + LAT_W'(rad);
  end

  assign pipe_en   = !(out_valid_r && out_stall);
  assign in_stall  = !pipe_en;
  assign in_acc    = in_valid && pipe_en;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ERODE;
      len_r    <= 4'd3;
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= mode_t'(cfg_data[1:0]);
        REG_LENGTH: len_r    <= cfg_data[3:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // position and centre tracking
  always_comb begin
    px          = in_cmd ? 8'd0 : in_pixel;
    row_in_img  = in_row_r < h_eff;
    col_wrap    = (DIM_W'(in_col_r) + DIM_W'(1)) >= w_eff;
    ctl0.emit   = k_r >= CNT_W'(lat);
    ctl0.inner  = ({1'b0, cr_r} >= rad11) && ({1'b0, cc_r} >= rad11) &&
                  (({1'b0, cr_r} + rad11) < h_eff) && (({1'b0, cc_r} + rad11) < w_eff);
    ctl0.fin    = ({1'b0, cr_r} == h_eff - DIM_W'(1)) && ({1'b0, cc_r} == w_eff - DIM_W'(1));
    ctl0.cr     = cr_r;
    ctl0.cc     = cc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
      slot_r   <= '0;
      k_r      <= '0;
      cr_r     <= '0;
      cc_r     <= '0;
    end else if (cfg_acc && cfg_index <= REG_HEIGHT) begin
      in_row_r <= '0;
      in_col_r <= '0;
      slot_r   <= '0;
      k_r      <= '0;
      cr_r     <= '0;
      cc_r     <= '0;
    end else if (in_acc) begin
      if (ctl0.emit && ctl0.fin) begin
        in_row_r <= '0;
        in_col_r <= '0;
        slot_r   <= '0;
        k_r      <= '0;
        cr_r     <= '0;
        cc_r     <= '0;
      end else begin
        k_r <= k_r + CNT_W'(1);
        if (col_wrap) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + DIM_W'(1);
          slot_r   <= (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
        if (ctl0.emit) begin
          if ((DIM_W'(cc_r) + DIM_W'(1)) >= w_eff) begin
            cc_r <= '0;
            cr_r <= cr_r + COL_W'(1);
          end else begin
            cc_r <= cc_r + COL_W'(1);
          end
        end
      end
    end
  end

  // line buffer: one bank per row slot, all banks read at the current column
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_bank
    logic [7:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (in_acc) begin
        if (row_in_img && slot_r == SLOT_W'(g)) mem[in_col_r] <= px;
        rd_r[g] <= mem[in_col_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= in_acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ctl1_r  <= ctl0;
      px1_r   <= px;
      slot1_r <= slot_r;
    end
    if (pipe_en) ctl2_r <= ctl1_r;
  end

  // column reduction over the rows of the window; current row bypasses the bank
  always_comb begin
    logic [7:0]        v;
    logic [SLOT_W-1:0] d;
    col_all = 1'b1;
    col_any = 1'b0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      v = (slot1_r == SLOT_W'(i)) ? px1_r : rd_r[i];
      d = (slot1_r >= SLOT_W'(i)) ? slot1_r - SLOT_W'(i)
                                  : slot1_r + SLOT_W'(MAX_WINDOW) - SLOT_W'(i);
      if (d <= {rad, 1'b0}) begin
        if (v == WHITE) col_any = 1'b1;
        else            col_all = 1'b0;
      end
    end
    i1   = (slot1_r == '0) ? SLOT_W'(MAX_WINDOW - 1) : slot1_r - SLOT_W'(1);
    i2   = (i1 == '0) ? SLOT_W'(MAX_WINDOW - 1) : i1 - SLOT_W'(1);
    cmin = px1_r;
    cmax = px1_r;
    if (rd_r[i1] < cmin) cmin = rd_r[i1];
    if (rd_r[i2] < cmin) cmin = rd_r[i2];
    if (rd_r[i1] > cmax) cmax = rd_r[i1];
    if (rd_r[i2] > cmax) cmax = rd_r[i2];
  end

  // horizontal history, newest column at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hall_r <= '0;
      hany_r <= '0;
    end else if (pipe_en && v1_r) begin
      hall_r <= {hall_r[MAX_WINDOW-2:0], col_all};
      hany_r <= {hany_r[MAX_WINDOW-2:0], col_any};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && v1_r) begin
      hmin_r[0] <= cmin;
      hmin_r[1] <= hmin_r[0];
      hmin_r[2] <= hmin_r[1];
      hmax_r[0] <= cmax;
      hmax_r[1] <= hmax_r[0];
      hmax_r[2] <= hmax_r[1];
    end
  end

  always_comb begin
    logic [MAX_WINDOW-1:0] hmask;
    logic [7:0]            gmin, gmax;
    hmask = MAX_WINDOW'((16'd1 << ({rad, 1'b0} + 4'd1)) - 16'd1);
    gmin  = hmin_r[0];
    gmax  = hmax_r[0];
    for (int j = 1; j < 3; j++) begin
      if (hmin_r[j] < gmin) gmin = hmin_r[j];
      if (hmax_r[j] > gmax) gmax = hmax_r[j];
    end
    case (mode_r)
      MODE_ERODE:  value_nxt = (&(hall_r | ~hmask)) ? WHITE : 8'd0;
      MODE_DILATE: value_nxt = (|(hany_r & hmask)) ? WHITE : 8'd0;
      MODE_GMIN:   value_nxt = gmin;
      MODE_GMAX:   value_nxt = gmax;
      default:     value_nxt = 8'd0;
    endcase
    if (!ctl2_r.inner) value_nxt = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= v2_r && ctl2_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_value_r <= value_nxt;
      out_row_r   <= ctl2_r.cr;
      out_col_r   <= ctl2_r.cc;
      out_last_r  <= ctl2_r.fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(in_col_r) < w_eff)
    else $error("input column beyond image width");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(MAX_WINDOW))
    else $error("row slot out of range");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> DIM_W'(out_col_r) == w_eff - DIM_W'(1))
    else $error("last flag away from final column");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the morphological window filter. Streams small
// images (plus a few extreme sizes) under every mode, predicts each filtered
// centre in-bench and compares every result transfer against it.
// ----------------------------------------------------------------------------
module tb;
  import mwf_pkg::*;

  typedef struct {
    logic       cmd;
    logic [7:0] pixel;
  } pix_item_t;

  typedef struct {
    logic [7:0]       value;
    logic [COL_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } centre_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = 1'b0;
  logic [7:0]        in_pixel = 8'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_value;
  logic [COL_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  morphological_window_filter u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending pixels and expected centres
  pix_item_t pix_q[$];
  centre_t   centre_q[$];
  int        n_fail = 0;
  int        n_in = 0;
  int        n_out = 0;
  int        quiet = 0;

  // filter state mirror
  logic [7:0]  rows_mem [MAX_WINDOW][MAX_WIDTH];
  logic [1:0]  m_mode = MODE_ERODE;
  logic [3:0]  m_len = 4'd3;
  logic [10:0] m_width = 11'd640;
  logic [10:0] m_height = 11'd480;
  int          pos_row = 0;
  int          pos_col = 0;

  function automatic int eff_w();
    return (m_width < 1) ? 1 : (m_width > MAX_WIDTH) ? MAX_WIDTH : int'(m_width);
  endfunction

  function automatic int eff_h();
    return (m_height < 1) ? 1 : (m_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(m_height);
  endfunction

  function automatic int eff_r();
    int len;
    if (m_mode == MODE_GMIN || m_mode == MODE_GMAX) return 1;
    len = (m_len < 1) ? 1 : int'(m_len);
    return len / 2;
  endfunction

  function automatic logic [7:0] reduce_window(int cr, int cc, int r);
    logic all_w, any_w;
    logic [7:0] lo, hi, v;
    all_w = 1'b1; any_w = 1'b0; lo = 8'd255; hi = 8'd0;
    for (int x = cr - r; x <= cr + r; x++) begin
      for (int y = cc - r; y <= cc + r; y++) begin
        v = rows_mem[x % MAX_WINDOW][y % MAX_WIDTH];
        if (v == WHITE) any_w = 1'b1; else all_w = 1'b0;
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
    end
    case (mode_t'(m_mode))
      MODE_ERODE:  return all_w ? WHITE : 8'd0;
      MODE_DILATE: return any_w ? WHITE : 8'd0;
      MODE_GMIN:   return lo;
      default:     return hi;
    endcase
  endfunction

  function automatic void predict_centre(pix_item_t it);
    int w, h, r, lat, k, ctr, cr, cc;
    centre_t c;
    w = eff_w(); h = eff_h(); r = eff_r();
    lat = r * w + r;
    k = pos_row * w + pos_col;
    if (pos_row < h) rows_mem[pos_row % MAX_WINDOW][pos_col % MAX_WIDTH] = it.cmd ? 8'd0 : it.pixel;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (k >= lat) begin
      ctr = k - lat;
      cr = ctr / w;
      cc = ctr % w;
      if (cr < h) begin
        c.value = (cr >= r && cc >= r && cr + r < h && cc + r < w) ?
                  reduce_window(cr, cc, r) : 8'd0;
        c.row = cr[COL_W-1:0];
        c.col = cc[COL_W-1:0];
        c.last = (ctr == w * h - 1);
        centre_q.push_back(c);
        if (c.last) begin
          pos_row = 0;
          pos_col = 0;
        end
      end
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_centre('{cmd: in_cmd, pixel: in_pixel});
        n_in++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (pix_q.size() > 0 &&
                   ((n_in > 250 && n_in < 450) || $urandom_range(0, 99) >= 29)) begin
        in_valid <= 1'b1;
        in_cmd   <= pix_q[0].cmd;
        in_pixel <= pix_q[0].pixel;
        void'(pix_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  int hold_off = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (centre_q.size() == 0) begin
        $display("%0t: unexpected result value=%0d row=%0d col=%0d last=%0b",
                 $time, out_value, out_row, out_col, out_last);
        n_fail++;
      end else begin
        if (out_value !== centre_q[0].value || out_row !== centre_q[0].row ||
            out_col !== centre_q[0].col || out_last !== centre_q[0].last) begin
          $display("%0t: mismatch expected value=%0d row=%0d col=%0d last=%0b",
                   $time, centre_q[0].value, centre_q[0].row, centre_q[0].col,
                   centre_q[0].last);
          $display("%0t:          actual   value=%0d row=%0d col=%0d last=%0b",
                   $time, out_value, out_row, out_col, out_last);
          n_fail++;
        end
        void'(centre_q.pop_front());
      end
    end
    if (!hold_done && n_out >= 150) begin
      hold_done <= 1'b1;
      hold_off  <= 400;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (n_out > 500 && n_out < 800) ? 1'b0 : ($urandom_range(0, 99) < 29);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pix_q.size() > 0 || in_valid || centre_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:   m_mode = data[1:0];
      REG_LENGTH: m_len = data[3:0];
      REG_WIDTH:  m_width = data;
      REG_HEIGHT: m_height = data;
      default:    return;
    endcase
    pos_row = 0;
    pos_col = 0;
  endtask

  task automatic set_filter(mode_t md, int len, int w, int h);
    wait_idle();
    write_reg(REG_MODE, CFG_DW'(md));
    write_reg(REG_LENGTH, CFG_DW'(len));
    write_reg(REG_WIDTH, CFG_DW'(w));
    write_reg(REG_HEIGHT, CFG_DW'(h));
  endtask

  function automatic logic [7:0] rand_pixel();
    if ((m_mode == MODE_ERODE || m_mode == MODE_DILATE) && $urandom_range(0, 9) < 7)
      return $urandom_range(0, 1) ? WHITE : 8'd0;
    return 8'($urandom);
  endfunction

  // queue a whole image plus its flush pads, or a truncated one
  task automatic queue_image(int n_cut);
    int total;
    pix_item_t it;
    total = eff_w() * eff_h() + eff_r() * eff_w() + eff_r();
    if (n_cut > 0 && n_cut < total) total = n_cut;
    for (int i = 0; i < total; i++) begin
      it.cmd = ($urandom_range(0, 99) < 6);
      it.pixel = rand_pixel();
      pix_q.push_back(it);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // all-white 3x3 erosion, then a single white dot dilated
    set_filter(MODE_ERODE, 3, 3, 3);
    for (int i = 0; i < 13; i++) pix_q.push_back('{cmd: (i >= 9), pixel: WHITE});
    set_filter(MODE_DILATE, 3, 3, 3);
    for (int i = 0; i < 13; i++)
      pix_q.push_back('{cmd: (i == 7 || i >= 9), pixel: (i == 4) ? WHITE : 8'd0});
    wait_idle();
    write_reg(CFG_AW'(5), 11'd7);  // unmapped index
    set_filter(MODE_GMIN, 0, 0, 0);
    queue_image(0);
    set_filter(MODE_GMAX, 15, 8, 8);
    queue_image(0);
    set_filter(MODE_ERODE, 15, 16, 16);
    queue_image(0);

    // extreme sizes, cut short
    set_filter(MODE_GMAX, 1, 1024, 3);
    queue_image(40);
    set_filter(MODE_DILATE, 3, 3, 1024);
    queue_image(60);
    set_filter(MODE_GMIN, 2, 2047, 2047 & 11'h3);
    queue_image(40);

    // random images
    while (n_in + pix_q.size() < 700) begin
      set_filter(mode_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                 $urandom_range(0, 24), $urandom_range(0, 12));
      repeat ($urandom_range(1, 2)) queue_image(0);
      if ($urandom_range(0, 99) < 15) queue_image($urandom_range(1, 40));
    end

    wait_idle();
    if (n_fail == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/mwf_pkg.sv
src/morphological_window_filter.sv
tb/tb.sv
